### rtl/cbcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbcm_pkg;

  // Model geometry
  localparam int CTX_BITS   = 5;
  localparam int ORDER      = 2;
  localparam int COUNT_BITS = 16;
  localparam int HIST_BITS  = ORDER * CTX_BITS;
  localparam int HIST_W     = (HIST_BITS > 0) ? HIST_BITS : 1;
  localparam int ADDR_BITS  = 10;
  localparam int DEPTH      = 1 << ADDR_BITS;

  // Fixed field widths
  localparam int OPCODE_W   = 3;
  localparam int CVAL_W     = 5;
  localparam int FIELD_W    = 17;
  localparam int SHIFT_W    = 4;
  localparam int MAXCNT_W   = 16;

  localparam logic [MAXCNT_W-1:0] MAXCNT_RESET = MAXCNT_W'(255);

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_SCALE  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ENCODE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DECODE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SHIFT  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_FLUSH  = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                bit_req;
    logic [CVAL_W-1:0]   context_value;
    logic [FIELD_W-1:0]  count;
    logic [SHIFT_W-1:0]  scale_shift;
  } req_t;

  typedef struct packed {
    logic               bit_out;
    logic [FIELD_W-1:0] ival_lo;
    logic [FIELD_W-1:0] ival_hi;
    logic [FIELD_W-1:0] scale;
  } rsp_t;

  // One memory word: count1 in the upper half, count0 in the lower half
  typedef struct packed {
    logic [COUNT_BITS-1:0] c1;
    logic [COUNT_BITS-1:0] c0;
  } cnt_pair_t;

  localparam int PAIR_W = $bits(cnt_pair_t);

  // Count memory access request
  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    cnt_pair_t            wr_data;
  } ram_req_t;

  // Result beat towards the output register
  typedef struct packed {
    logic push;
    rsp_t data;
  } rsp_push_t;

  // Right shift of both counts, each held at one or more
  function automatic cnt_pair_t shrink_pair(input cnt_pair_t p, input logic [SHIFT_W-1:0] sh);
    cnt_pair_t r;
    r.c0 = p.c0 >> sh;
    r.c1 = p.c1 >> sh;
    if (r.c0 == '0) r.c0 = COUNT_BITS'(1);
    if (r.c1 == '0) r.c1 = COUNT_BITS'(1);
    return r;
  endfunction

  // Saturating increment of one count, then halving once the limit is reached
  function automatic cnt_pair_t update_pair(input cnt_pair_t p, input logic b,
                                            input logic [MAXCNT_W-1:0] lim);
    logic [COUNT_BITS-1:0] c;
    logic [COUNT_BITS-1:0] inc;
    cnt_pair_t             n;
    c   = b ? p.c1 : p.c0;
    inc = (c != '1) ? c + COUNT_BITS'(1) : c;
    n.c0 = b ? p.c0 : inc;
    n.c1 = b ? inc : p.c1;
    if (MAXCNT_W'(inc) >= lim) n = shrink_pair(n, SHIFT_W'(1));
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/cbcm_count_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module cbcm_count_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/cbcm_rsp_reg.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register: holds one result beat until the consumer takes it
module cbcm_rsp_reg import cbcm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rsp_push_t in_beat,
  output      logic      space,
  output      logic      rsp_valid,
  input  wire logic      rsp_stall,
  output      rsp_t      rsp
);

  assign space = !rsp_valid || !rsp_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (in_beat.push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_beat.push) rsp <= in_beat.data;
  end

endmodule

`default_nettype wire

### rtl/cbcm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: context history, memory read-modify-write, flush and clear sweeps
module cbcm_seq import cbcm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_stall,
  input  wire req_t                req,
  input  wire logic                limit_we,
  input  wire logic [MAXCNT_W-1:0] limit_data,
  output      ram_req_t            ram_req,
  input  wire cnt_pair_t           rd_data,
  output      rsp_push_t           out_beat,
  input  wire logic                rsp_space
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [HIST_W-1:0]     hist;
  logic [MAXCNT_W-1:0]   halve_limit;
  req_t                  cmd;
  logic [ADDR_BITS:0]    sweep_idx;
  logic [ADDR_BITS:0]    sweep_idx_next;
  logic                  wb_pend;
  logic [ADDR_BITS-1:0]  wb_addr;
  logic                  accept;
  logic [ADDR_BITS-1:0]  cur_addr;
  logic [FIELD_W-1:0]    c0x;
  logic [FIELD_W-1:0]    c1x;
  logic [FIELD_W-1:0]    scale_v;
  logic                  sel_bit;
  cnt_pair_t             one_pair;
  rsp_t                  beat_data;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cur_addr  = ADDR_BITS'(hist);
  assign one_pair  = '{c1: COUNT_BITS'(1), c0: COUNT_BITS'(1)};

  // result arithmetic on the word just read
  assign c0x     = FIELD_W'(rd_data.c0);
  assign c1x     = FIELD_W'(rd_data.c1);
  assign scale_v = c0x + c1x;
  assign sel_bit = (cmd.opcode == OP_DECODE) ? (cmd.count >= c0x) : cmd.bit_req;

  always_comb begin
    beat_data.bit_out = sel_bit;
    beat_data.scale   = scale_v;
    beat_data.ival_lo = sel_bit ? c0x : '0;
    beat_data.ival_hi = sel_bit ? scale_v : c0x;
    if (cmd.opcode == OP_SCALE) begin
      beat_data.ival_lo = '0;
      beat_data.ival_hi = '0;
    end
  end

  // control and memory requests
  always_comb begin
    state_next       = state;
    sweep_idx_next   = sweep_idx;
    ram_req.rd_en    = 1'b0;
    ram_req.rd_addr  = cur_addr;
    ram_req.wr_en    = 1'b0;
    ram_req.wr_addr  = cur_addr;
    ram_req.wr_data  = update_pair(rd_data, cmd.bit_req, halve_limit);
    out_beat.push    = 1'b0;
    out_beat.data    = beat_data;
    unique case (state)
      ST_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = sweep_idx[ADDR_BITS-1:0];
        ram_req.wr_data = one_pair;
        sweep_idx_next  = sweep_idx + (ADDR_BITS + 1)'(1);
        if (sweep_idx[ADDR_BITS-1:0] == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req.opcode) inside
            OP_SCALE, OP_ENCODE, OP_DECODE, OP_UPDATE: begin
              ram_req.rd_en = 1'b1;
              state_next    = ST_EXEC;
            end
            OP_FLUSH: begin
              sweep_idx_next = '0;
              state_next     = ST_FLUSH;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (cmd.opcode == OP_UPDATE) begin
          ram_req.wr_en = 1'b1;
          state_next    = ST_IDLE;
        end else if (rsp_space) begin
          out_beat.push = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        ram_req.rd_en   = !sweep_idx[ADDR_BITS];
        ram_req.rd_addr = sweep_idx[ADDR_BITS-1:0];
        ram_req.wr_en   = wb_pend;
        ram_req.wr_addr = wb_addr;
        ram_req.wr_data = shrink_pair(rd_data, cmd.scale_shift);
        if (!sweep_idx[ADDR_BITS]) begin
          sweep_idx_next = sweep_idx + (ADDR_BITS + 1)'(1);
        end else if (!wb_pend) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // state, sweep pointer and pending write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep_idx <= '0;
      wb_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_idx <= sweep_idx_next;
      wb_pend   <= (state == ST_FLUSH) && ram_req.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= ram_req.rd_addr;
  end

  // latched command beat
  always_ff @(posedge clk) begin
    if (accept) cmd <= req;
  end

  // context history, newest value in the low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (accept && req.opcode == OP_SHIFT && HIST_BITS > 0) begin
      hist <= HIST_W'({hist, CTX_BITS'(req.context_value)});
    end
  end

  // halving limit
  always_ff @(posedge clk) begin
    if (rst) begin
      halve_limit <= MAXCNT_RESET;
    end else if (limit_we) begin
      halve_limit <= limit_data;
    end
  end

endmodule

`default_nettype wire

### rtl/binary_context_count_model_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Adaptive binary context model with its counts in a 1024-entry memory addressed
// by the history of recent context values. Scale query, encode, decode and update
// each read the count memory on acceptance, then compute and either write the
// entry back or load the result register. Shift context updates the history as
// the beat is accepted. Flush sweeps the whole memory with reads and write-backs
// overlapped and holds the block until its last write-back. After reset a
// clearing pass sets every entry to counts (1,1); req_stall is high
// throughout it. Results wait in an output register, so a new beat is taken while
// an earlier result is still pending; only a result-producing operation that
// finds that register full and stalled waits for it. The halving limit may be
// written at any time the block is idle.
module binary_context_count_model_unit import cbcm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_stall,
  input  wire req_t                req,
  output      logic                rsp_valid,
  input  wire logic                rsp_stall,
  output      rsp_t                rsp,
  input  wire logic                limit_we,
  input  wire logic [MAXCNT_W-1:0] limit_data
);

  ram_req_t    ram_req;
  logic [PAIR_W-1:0] ram_rd_data;
  cnt_pair_t   rd_pair;
  rsp_push_t   out_beat;
  logic        rsp_space;

  assign rd_pair = ram_rd_data;

  cbcm_count_ram #(
    .DATA_W (PAIR_W),
    .ADDR_W (ADDR_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  cbcm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .limit_we   (limit_we),
    .limit_data (limit_data),
    .ram_req    (ram_req),
    .rd_data    (rd_pair),
    .out_beat   (out_beat),
    .rsp_space  (rsp_space)
  );

  cbcm_rsp_reg u_rsp (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (out_beat),
    .space     (rsp_space),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### rtl/cbcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the context model
module cbcm_checker import cbcm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // a stalled result beat stays
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result beat dropped while stalled");

  // busy with the clearing pass straight after reset
  assert property (@(posedge clk) rst |=> req_stall)
    else $error("input taken during clearing pass");

  // interval lies inside [0, scale]
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.ival_lo <= rsp.ival_hi) && (rsp.ival_hi <= rsp.scale))
    else $error("interval outside scale");

  // both counts are at least one
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.scale >= FIELD_W'(2))
    else $error("scale below two");

endmodule

bind binary_context_count_model_unit cbcm_checker u_cbcm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
